FILE: sv/rectified_stereo_triangulation_macros.svh
// Assertion macros shared by the triangulation RTL.
`ifndef RECTIFIED_STEREO_TRIANGULATION_MACROS_SVH
`define RECTIFIED_STEREO_TRIANGULATION_MACROS_SVH

// Clocked implication checked outside reset.
`define RST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property checked during reset as well.
`define RST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/rst_pkg.sv
// Shared widths, register indexes and the divider chain record.
package rst_pkg;

   localparam int COORD_BITS = 16;
   localparam int INDEX_BITS = 16;
   localparam int CFG_BITS   = 16;
   localparam int MEAS_BITS  = 16;
   localparam int CSR_IDX_BITS = 8;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int YSUM_BITS = COORD_BITS + 2;
   localparam int DIV_BITS  = COORD_BITS + 1;
   localparam int DVD_BITS  = (COORD_BITS + 17 > 32) ? COORD_BITS + 17 : 32;

   localparam int IN_RAW_BITS = 4 * COORD_BITS + INDEX_BITS;
   localparam int IN_BITS     = ((IN_RAW_BITS + 7) / 8) * 8;
   localparam int OUT_RAW_BITS = 32 + 32 + 31 + 3 * MEAS_BITS;
   localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FOCAL    = 8'd0,
      REG_CENTER_X = 8'd1,
      REG_CENTER_Y = 8'd2,
      REG_BASELINE = 8'd3,
      REG_MIN_DISP = 8'd4,
      REG_MAX_ROW  = 8'd5
   } reg_index_type;

   // One division lane: partial remainder and a word that shifts dividend
   // bits out at the top while quotient bits enter at the bottom.
   typedef struct packed {
      logic [DIV_BITS-1:0] rem;
      logic [DVD_BITS-1:0] dq;
   } lane_type;

   typedef struct packed {
      logic                  valid;
      logic                  keep;
      logic                  x_neg;
      logic                  y_neg;
      logic [DIV_BITS-1:0]   div_d;
      logic [DIV_BITS-1:0]   div_2d;
      lane_type              lane_z;
      lane_type              lane_x;
      lane_type              lane_y;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [INDEX_BITS-1:0] idx;
   } cell_data_type;

endpackage

FILE: sv/rst_div_cell.sv
// One restoring-division cell: produces one quotient bit for each of three lanes.
module rst_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  rst_pkg::cell_data_type data_in,
   output rst_pkg::cell_data_type data_out
);
   import rst_pkg::*;

   cell_data_type data_ff, data_in_q;

   function automatic lane_type lane_step(lane_type l, logic [DIV_BITS-1:0] dv);
      logic [DIV_BITS:0] sh;
      logic              ge;
      lane_type          r;
      sh = {l.rem, l.dq[DVD_BITS-1]};
      ge = (sh >= {1'b0, dv});
      r.rem = ge ? DIV_BITS'(sh - {1'b0, dv}) : sh[DIV_BITS-1:0];
      r.dq  = {l.dq[DVD_BITS-2:0], ge};
      return r;
   endfunction

   always_comb begin
      data_in_q = data_in;
      data_in_q.lane_z = lane_step(data_in.lane_z, data_in.div_d);
      data_in_q.lane_x = lane_step(data_in.lane_x, data_in.div_d);
      data_in_q.lane_y = lane_step(data_in.lane_y, data_in.div_2d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (enable) begin
         data_ff <= data_in_q;
      end
   end

   assign data_out = data_ff;

endmodule

FILE: sv/rectified_stereo_triangulation.sv
// Top level: match filter, products, divider cell chain and result register.
// One stereo match is accepted per cycle whenever the result register is empty
// or being taken. The match passes, in order, through a register for the
// disparity and filter tests, one for the three products, a chain of
// restoring-division cells with one cell per quotient bit, and the
// saturating result register. Matches that fail the tests or give zero depth
// produce no result. Configuration writes are taken in every cycle.
`include "rectified_stereo_triangulation_macros.svh"

module rectified_stereo_triangulation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // left_col, left_row, right_col, right_row, left_index
   input  logic [rst_pkg::IN_BITS-1:0]        req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // point_x, point_y, point_z, meas_col, meas_row, meas_index
   output logic [rst_pkg::OUT_BITS-1:0]       rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rst_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rst_pkg::CFG_BITS-1:0]       csr_data
);
   import rst_pkg::*;

   logic [CFG_BITS-1:0] focal_ff, cx_ff, cy_ff, base_ff, min_ff, maxrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= 16'd11502;
         cx_ff     <= 16'd9715;
         cy_ff     <= 16'd2963;
         base_ff   <= 16'd540;
         min_ff    <= 16'd16;
         maxrow_ff <= 16'd160;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FOCAL:    focal_ff  <= csr_data;
            REG_CENTER_X: cx_ff     <= csr_data;
            REG_CENTER_Y: cy_ff     <= csr_data;
            REG_BASELINE: base_ff   <= csr_data;
            REG_MIN_DISP: min_ff    <= csr_data;
            REG_MAX_ROW:  maxrow_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic advance;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_data_ff, rsp_data_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Stage 1: disparity, row test, centered coordinates.
   logic [COORD_BITS-1:0] lc, lr, rc, rr, cx, cy;
   logic [INDEX_BITS-1:0] li;
   logic signed [DIFF_BITS-1:0] d_s;
   logic [COORD_BITS-1:0] row_diff;
   logic keep_in;
   logic signed [DIFF_BITS-1:0] x1_in;
   logic signed [YSUM_BITS-1:0] ysum_in;

   assign lc = req_tdata[COORD_BITS-1:0];
   assign lr = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign rc = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign rr = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign li = req_tdata[4*COORD_BITS+INDEX_BITS-1:4*COORD_BITS];
   assign cx = COORD_BITS'(cx_ff);
   assign cy = COORD_BITS'(cy_ff);

   always_comb begin
      d_s      = $signed({1'b0, lc}) - $signed({1'b0, rc});
      row_diff = (lr >= rr) ? COORD_BITS'(lr - rr) : COORD_BITS'(rr - lr);
      // Only positive disparity can give positive depth.
      keep_in  = !d_s[DIFF_BITS-1] && (d_s[COORD_BITS-1:0] > min_ff)
                 && (row_diff < maxrow_ff);
      x1_in    = $signed({1'b0, lc}) - $signed({1'b0, cx});
      ysum_in  = $signed({2'b00, lr}) + $signed({2'b00, rr})
                 - $signed({1'b0, cy, 1'b0});
   end

   logic                        s1_valid_ff, s1_keep_ff;
   logic [COORD_BITS-1:0]       s1_d_ff, s1_col_ff, s1_row_ff;
   logic signed [DIFF_BITS-1:0] s1_x1_ff;
   logic signed [YSUM_BITS-1:0] s1_ysum_ff;
   logic [INDEX_BITS-1:0]       s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s1_keep_ff <= keep_in;
         s1_d_ff    <= d_s[COORD_BITS-1:0];
         s1_x1_ff   <= x1_in;
         s1_ysum_ff <= ysum_in;
         s1_col_ff  <= lc;
         s1_row_ff  <= lr;
         s1_idx_ff  <= li;
      end
   end

   // Stage 2: the three dividends as magnitudes with their signs.
   logic [COORD_BITS-1:0] x1_mag;
   logic [COORD_BITS:0]   ysum_mag;
   cell_data_type chain [0:DVD_BITS];
   cell_data_type head_in;

   always_comb begin
      x1_mag   = s1_x1_ff[DIFF_BITS-1] ? COORD_BITS'($unsigned(-s1_x1_ff))
                                       : COORD_BITS'($unsigned(s1_x1_ff));
      ysum_mag = s1_ysum_ff[YSUM_BITS-1] ? (COORD_BITS+1)'($unsigned(-s1_ysum_ff))
                                         : (COORD_BITS+1)'($unsigned(s1_ysum_ff));
      head_in.valid       = s1_valid_ff;
      head_in.keep        = s1_keep_ff;
      head_in.x_neg       = s1_x1_ff[DIFF_BITS-1];
      head_in.y_neg       = s1_ysum_ff[YSUM_BITS-1];
      head_in.div_d       = {1'b0, s1_d_ff};
      head_in.div_2d      = {s1_d_ff, 1'b0};
      head_in.lane_z.rem  = '0;
      head_in.lane_z.dq   = DVD_BITS'(focal_ff * base_ff);
      head_in.lane_x.rem  = '0;
      head_in.lane_x.dq   = DVD_BITS'(x1_mag * base_ff);
      head_in.lane_y.rem  = '0;
      head_in.lane_y.dq   = DVD_BITS'(ysum_mag * base_ff);
      head_in.col         = s1_col_ff;
      head_in.row         = s1_row_ff;
      head_in.idx         = s1_idx_ff;
   end

   cell_data_type head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < DVD_BITS; g++) begin : g_cell
      rst_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .data_in  (chain[g]),
         .data_out (chain[g+1])
      );
   end

   // Result: signs, saturation and the depth test.
   cell_data_type tail;
   logic [DVD_BITS-1:0] zq, xq, yq;
   logic [31:0] x_val, y_val;
   logic [30:0] z_val;
   logic        tail_emit;

   always_comb begin
      tail = chain[DVD_BITS];
      zq   = tail.lane_z.dq;
      xq   = tail.lane_x.dq;
      yq   = tail.lane_y.dq;
      z_val = (zq > 'h7FFF_FFFF) ? 31'h7FFF_FFFF : zq[30:0];
      if (tail.x_neg) begin
         x_val = (xq > 'h8000_0000) ? 32'h8000_0000 : 32'(0 - xq);
      end else begin
         x_val = (xq > 'h7FFF_FFFF) ? 32'h7FFF_FFFF : xq[31:0];
      end
      if (tail.y_neg) begin
         y_val = (yq > 'h8000_0000) ? 32'h8000_0000 : 32'(0 - yq);
      end else begin
         y_val = (yq > 'h7FFF_FFFF) ? 32'h7FFF_FFFF : yq[31:0];
      end
      tail_emit    = tail.valid && tail.keep && (zq != '0);
      rsp_valid_in = tail_emit;
      rsp_data_in  = OUT_BITS'({MEAS_BITS'(tail.idx), MEAS_BITS'(tail.row),
                                MEAS_BITS'(tail.col), z_val, y_val, x_val});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RST_ASSERT(a_depth_positive, clock, reset, rsp_valid_ff |-> (rsp_data_ff[94:64] != '0), "result with zero depth")
   `RST_ASSERT(a_stall_blocks, clock, reset, (rsp_valid_ff && !rsp_tready) |-> !req_tready, "request taken while result stalled")
   `RST_ASSERT(a_emit_lands, clock, reset, (advance && tail_emit) |=> rsp_valid_ff, "finished result lost")

endmodule
